### design/sbcd_pkg.sv
// sbcd_pkg: shared types and codes of the block command decoder
// holds the transaction payload structs, the decode state and the opcode codes
// no dependencies
`default_nettype none

package sbcd_pkg;

   // operation codes handled by the decoder
   localparam logic [7:0] OP_FORMAT_UNIT   = 8'h04;
   localparam logic [7:0] OP_READ6         = 8'h08;
   localparam logic [7:0] OP_WRITE6        = 8'h0A;
   localparam logic [7:0] OP_SEEK6         = 8'h0B;
   localparam logic [7:0] OP_INQUIRY       = 8'h12;
   localparam logic [7:0] OP_MODE_SELECT6  = 8'h15;
   localparam logic [7:0] OP_MODE_SENSE6   = 8'h1A;
   localparam logic [7:0] OP_READ_CAPACITY = 8'h25;
   localparam logic [7:0] OP_READ10        = 8'h28;
   localparam logic [7:0] OP_WRITE10       = 8'h2A;
   localparam logic [7:0] OP_READ12        = 8'hA8;

   // bus phases
   localparam logic [1:0] PH_STATUS  = 2'd0;
   localparam logic [1:0] PH_DATAIN  = 2'd1;
   localparam logic [1:0] PH_DATAOUT = 2'd2;

   // item kinds
   localparam logic ACT_COMMAND = 1'b0;
   localparam logic ACT_SECTOR  = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECTOR_SIZE   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEDIA_PRESENT = 4'd1;

   localparam logic [15:0] SECTOR_SIZE_RESET   = 16'd512;
   localparam logic        MEDIA_PRESENT_RESET = 1'b1;
   localparam logic [31:0] CAPACITY_LENGTH     = 32'd8;

   typedef struct packed {
      logic       action;
      logic [7:0] opcode;
      logic [7:0] cdb_byte1;
      logic [7:0] cdb_byte2;
      logic [7:0] cdb_byte3;
      logic [7:0] cdb_byte4;
      logic [7:0] cdb_byte5;
      logic [7:0] cdb_byte6;
      logic [7:0] cdb_byte7;
      logic [7:0] cdb_byte8;
      logic [7:0] cdb_byte9;
   } req_type;

   typedef struct packed {
      logic [1:0]  bus_phase;
      logic        status_good;
      logic [31:0] transfer_length;
      logic [31:0] block_address;
      logic [31:0] block_count;
      logic        unsupported;
   } rsp_type;

   typedef struct packed {
      logic [31:0] lba;
      logic [31:0] count;
      logic [7:0]  last_opcode;
      logic [1:0]  phase;
      logic        status_good;
      logic [31:0] length;
   } state_type;

   localparam state_type STATE_RESET = '{
      lba:         32'd0,
      count:       32'd0,
      last_opcode: 8'd0,
      phase:       PH_STATUS,
      status_good: 1'b1,
      length:      32'd0
   };

endpackage

`default_nettype wire

### design/sbcd_decode.sv
// sbcd_decode: next-state logic for one transaction of the command decoder
// command decode, block count times sector size, sector advance
// depends on sbcd_pkg
`default_nettype none

module sbcd_decode (
   input  var sbcd_pkg::req_type   item,
   input  var sbcd_pkg::state_type state,
   input  wire logic [15:0]        sector_size,
   input  wire logic               media_present,
   output sbcd_pkg::state_type     state_in,
   output logic                    unsupported
);

   logic [8:0]  len6;
   logic [31:0] lba6;
   logic [31:0] lba10;
   logic [31:0] count_sel;
   logic [47:0] product;
   logic        block_mode;
   logic        last_block;

   // six-byte length: zero means 256
   assign len6  = (item.cdb_byte4 == 8'd0) ? 9'd256 : {1'b0, item.cdb_byte4};
   assign lba6  = {11'd0, item.cdb_byte1[4:0], item.cdb_byte2, item.cdb_byte3};
   assign lba10 = {item.cdb_byte2, item.cdb_byte3, item.cdb_byte4, item.cdb_byte5};

   always_comb begin
      unique case (item.opcode) inside
         sbcd_pkg::OP_READ6, sbcd_pkg::OP_WRITE6: count_sel = {23'd0, len6};
         sbcd_pkg::OP_READ10, sbcd_pkg::OP_WRITE10:
            count_sel = {16'd0, item.cdb_byte7, item.cdb_byte8};
         default: count_sel = {item.cdb_byte6, item.cdb_byte7,
                               item.cdb_byte8, item.cdb_byte9};
      endcase
   end

   assign product = count_sel * {16'd0, sector_size};

   always_comb begin
      unique case (state.last_opcode) inside
         sbcd_pkg::OP_READ6, sbcd_pkg::OP_WRITE6, sbcd_pkg::OP_READ10,
         sbcd_pkg::OP_WRITE10, sbcd_pkg::OP_READ12: last_block = 1'b1;
         default: last_block = 1'b0;
      endcase
   end

   assign block_mode = media_present && (state.count != 32'd0) && last_block;

   always_comb begin
      state_in    = state;
      unsupported = 1'b0;
      if (item.action == sbcd_pkg::ACT_SECTOR) begin
         if (block_mode) begin
            state_in.lba   = state.lba + 32'd1;
            state_in.count = state.count - 32'd1;
         end
      end else begin
         state_in.last_opcode = item.opcode;
         unique case (item.opcode) inside
            sbcd_pkg::OP_FORMAT_UNIT: begin
               state_in.phase       = sbcd_pkg::PH_STATUS;
               state_in.status_good = 1'b1;
               state_in.length      = 32'd0;
            end
            sbcd_pkg::OP_SEEK6: begin
               // status is left as the previous command set it
               state_in.lba    = lba6;
               state_in.phase  = sbcd_pkg::PH_STATUS;
               state_in.length = 32'd0;
            end
            sbcd_pkg::OP_READ6, sbcd_pkg::OP_WRITE6: begin
               state_in.lba         = lba6;
               state_in.count       = count_sel;
               state_in.phase       = (item.opcode == sbcd_pkg::OP_READ6) ?
                                      sbcd_pkg::PH_DATAIN : sbcd_pkg::PH_DATAOUT;
               state_in.status_good = 1'b1;
               state_in.length      = product[31:0];
            end
            sbcd_pkg::OP_READ10, sbcd_pkg::OP_WRITE10: begin
               state_in.lba         = lba10;
               state_in.count       = count_sel;
               state_in.phase       = (item.opcode == sbcd_pkg::OP_READ10) ?
                                      sbcd_pkg::PH_DATAIN : sbcd_pkg::PH_DATAOUT;
               state_in.status_good = 1'b1;
               state_in.length      = product[31:0];
            end
            sbcd_pkg::OP_READ12: begin
               state_in.lba         = lba10;
               state_in.count       = count_sel;
               state_in.phase       = sbcd_pkg::PH_DATAIN;
               state_in.status_good = 1'b1;
               state_in.length      = product[31:0];
            end
            sbcd_pkg::OP_INQUIRY, sbcd_pkg::OP_MODE_SENSE6: begin
               state_in.phase       = sbcd_pkg::PH_DATAIN;
               state_in.status_good = 1'b1;
               state_in.length      = {23'd0, len6};
            end
            sbcd_pkg::OP_MODE_SELECT6: begin
               state_in.phase       = sbcd_pkg::PH_DATAOUT;
               state_in.status_good = 1'b1;
               state_in.length      = {23'd0, len6};
            end
            sbcd_pkg::OP_READ_CAPACITY: begin
               state_in.phase       = sbcd_pkg::PH_DATAIN;
               state_in.status_good = 1'b1;
               state_in.length      = sbcd_pkg::CAPACITY_LENGTH;
            end
            default: begin
               state_in.phase       = sbcd_pkg::PH_STATUS;
               state_in.status_good = 1'b0;
               state_in.length      = 32'd0;
               unsupported          = 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### design/scsi_block_command_decoder.sv
// scsi_block_command_decoder: direct-access target command decoder, top level
// path: a transaction is held in the input register, then decoded into the output register
// throughput: one transaction per cycle while rsp_stall does not hold the output, set by the
// state update loop (decode plus one 32x16 multiply into the state registers)
// reset: synchronous, clears both stages and the decode state, reloads the csr reset values
// depends on sbcd_pkg and sbcd_decode
`default_nettype none

module scsi_block_command_decoder (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  var sbcd_pkg::req_type                      req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output sbcd_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [sbcd_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [15:0]                           csr_data
);

   logic                sector_size_ff_en;
   logic [15:0]         sector_size_ff;
   logic                media_present_ff;
   logic                in_valid_ff;
   sbcd_pkg::req_type   in_data_ff;
   logic                out_valid_ff;
   sbcd_pkg::rsp_type   out_data_ff;
   sbcd_pkg::state_type state_ff;
   sbcd_pkg::state_type state_in;
   sbcd_pkg::rsp_type   out_data_in;
   logic                unsupported;
   logic                out_load;
   logic                in_fire;
   logic                req_accept;

   assign csr_ready         = 1'b1;
   assign sector_size_ff_en = csr_valid && (csr_index == sbcd_pkg::CSR_SECTOR_SIZE);

   assign out_load   = !out_valid_ff || !rsp_stall;
   assign in_fire    = in_valid_ff && out_load;
   assign req_stall  = in_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   sbcd_decode u_decode (
      .item          (in_data_ff),
      .state         (state_ff),
      .sector_size   (sector_size_ff),
      .media_present (media_present_ff),
      .state_in      (state_in),
      .unsupported   (unsupported)
   );

   always_comb begin
      out_data_in.bus_phase       = state_in.phase;
      out_data_in.status_good     = state_in.status_good;
      out_data_in.transfer_length = state_in.length;
      out_data_in.block_address   = state_in.lba;
      out_data_in.block_count     = state_in.count;
      out_data_in.unsupported     = unsupported;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         state_ff         <= sbcd_pkg::STATE_RESET;
         sector_size_ff   <= sbcd_pkg::SECTOR_SIZE_RESET;
         media_present_ff <= sbcd_pkg::MEDIA_PRESENT_RESET;
      end else begin
         in_valid_ff <= req_accept || (in_valid_ff && !out_load);
         if (out_load) begin
            out_valid_ff <= in_fire;
         end
         if (in_fire) begin
            state_ff <= state_in;
         end
         if (sector_size_ff_en) begin
            sector_size_ff <= csr_data;
         end
         if (csr_valid && (csr_index == sbcd_pkg::CSR_MEDIA_PRESENT)) begin
            media_present_ff <= csr_data[0];
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (in_fire) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire
